// ===== rtl/core/xor_sprite_framebuffer_core_macros.svh =====
// Assertion helpers for the framebuffer core checker.
// Both sample on clk and are disabled while rst_n is low.
`ifndef XOR_SPRITE_FRAMEBUFFER_CORE_MACROS_SVH
`define XOR_SPRITE_FRAMEBUFFER_CORE_MACROS_SVH

// Same-cycle implication.
`define XSF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xsf check failed");

// Next-cycle implication.
`define XSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xsf check failed");

`endif

// ===== rtl/core/xsf_pkg.sv =====
`default_nettype none

package xsf_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;

    localparam int ROW_BITS      = 64;
    localparam int SPRITE_PIXELS = 8;
    localparam int ROW_AW        = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    // wide enough to hold any y_pos and SCREEN_HEIGHT itself
    localparam int ROW_CMP_W     = 7;
    localparam int COL_W         = 7;

    typedef enum logic [1:0] {
        ACT_DRAW  = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [5:0] x_pos;
        logic [4:0] y_pos;
        logic [7:0] sprite_bits;
    } in_item_t;

    typedef struct packed {
        logic                collision;
        logic [ROW_BITS-1:0] row_pixels;
    } out_item_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_UPDATE = 1'b1
    } state_t;

    typedef struct packed {
        logic load;    // latch item, issue row read
        logic update;  // modify/write row, load result
    } ctrl_cmd_t;

    function automatic logic [ROW_AW-1:0] row_addr(input logic [4:0] y);
        return ROW_AW'(y);
    endfunction

    function automatic logic row_in_range(input logic [4:0] y);
        return ROW_CMP_W'(y) < ROW_CMP_W'(SCREEN_HEIGHT);
    endfunction

    // Sprite byte placed in a row word, MSB at column x; columns past the edge drop.
    function automatic logic [ROW_BITS-1:0] sprite_mask(input logic [5:0] x,
                                                       input logic [7:0] bits);
        logic [ROW_BITS-1:0] mask;
        logic [COL_W-1:0]    col;
        mask = '0;
        for (int k = 0; k < SPRITE_PIXELS; k++) begin
            col = COL_W'(x) + COL_W'(k);
            if ((col < COL_W'(SCREEN_WIDTH)) && bits[SPRITE_PIXELS-1-k]) begin
                mask[col[5:0]] = 1'b1;
            end
        end
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/xsf_ram.sv =====
`default_nettype none

module xsf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/xsf_ctrl.sv =====
`default_nettype none

module xsf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               done,
    output xsf_pkg::ctrl_cmd_t cmd
);

    xsf_pkg::state_t state_reg;
    xsf_pkg::state_t state_next;
    logic            done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xsf_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.update;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            xsf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = xsf_pkg::ST_UPDATE;
                end
            end
            xsf_pkg::ST_UPDATE: state_next = xsf_pkg::ST_IDLE;
            default:            state_next = xsf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = 1'b0;
        cmd.load   = 1'b0;
        cmd.update = 1'b0;
        case (state_reg)
            xsf_pkg::ST_IDLE:   cmd.load = start;
            xsf_pkg::ST_UPDATE:
            begin
                busy       = 1'b1;
                cmd.update = 1'b1;
            end
            default:            busy = 1'b0;
        endcase
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/core/xsf_datapath.sv =====
`default_nettype none

module xsf_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire xsf_pkg::ctrl_cmd_t cmd,
    input  wire xsf_pkg::in_item_t  item,
    output xsf_pkg::out_item_t      result
);

    xsf_pkg::in_item_t               item_reg;
    xsf_pkg::out_item_t              result_reg;
    xsf_pkg::out_item_t              result_next;
    logic [xsf_pkg::SCREEN_HEIGHT-1:0] valid_reg;
    logic [xsf_pkg::SCREEN_HEIGHT-1:0] valid_next;

    logic [xsf_pkg::ROW_AW-1:0]   addr;
    logic                         in_range;
    logic [xsf_pkg::ROW_BITS-1:0] rd_data;
    logic [xsf_pkg::ROW_BITS-1:0] row_word;
    logic [xsf_pkg::ROW_BITS-1:0] mask;
    logic                         wr_en;

    // row store; rows not valid since the last clear read as zero
    xsf_ram #(
        .WIDTH (xsf_pkg::ROW_BITS),
        .DEPTH (xsf_pkg::SCREEN_HEIGHT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (addr),
        .wr_data (row_word ^ mask),
        .rd_en   (cmd.load),
        .rd_addr (xsf_pkg::row_addr(item.y_pos)),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.update)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign addr     = xsf_pkg::row_addr(item_reg.y_pos);
    assign in_range = xsf_pkg::row_in_range(item_reg.y_pos);
    assign row_word = (in_range && valid_reg[addr]) ? rd_data : '0;
    assign mask     = xsf_pkg::sprite_mask(item_reg.x_pos, item_reg.sprite_bits);

    always_comb
    begin
        wr_en       = 1'b0;
        valid_next  = valid_reg;
        result_next = '0;
        if (cmd.update)
        begin
            case (item_reg.action)
                xsf_pkg::ACT_DRAW:
                begin
                    if (in_range)
                    begin
                        wr_en                 = 1'b1;
                        valid_next[addr]      = 1'b1;
                        result_next.collision = |(row_word & mask);
                    end
                end
                xsf_pkg::ACT_CLEAR: valid_next = '0;
                xsf_pkg::ACT_READ:  result_next.row_pixels = row_word;
                default:            result_next = '0;
            endcase
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/core/xor_sprite_framebuffer_core.sv =====
// Channel   Signals                 Direction  Handshake
// item      start, busy, item       in         taken when start && !busy
// result    done, result            out        one-cycle strobe on done
//
// An accepted item is latched and its row read issued; the update state does
// the XOR/collision update, writes the row back and registers the result.
// done is high the cycle after that, while a new item may be taken. The
// single row RAM port pair has a registered read. Clear is instant: per-row
// valid flops are wiped and reset does the same. The receiver cannot stall.
`default_nettype none

module xor_sprite_framebuffer_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire xsf_pkg::in_item_t item,
    output logic                   done,
    output xsf_pkg::out_item_t     result
);

    // command bundle from sequencer to datapath
    xsf_pkg::ctrl_cmd_t cmd;

    // two-state sequencer: idle (accepts) and update (row read data ready)
    xsf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // row RAM, valid bits, sprite mask, collision test, result register
    xsf_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/xsf_checker.sv =====
`default_nettype none
`include "xor_sprite_framebuffer_core_macros.svh"

module xsf_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire xsf_pkg::in_item_t  item,
    input wire logic               done,
    input wire xsf_pkg::out_item_t result
);

    logic accept;
    logic accept_d1;
    logic non_read_d1;
    logic non_draw_d1;

    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accept_d1   <= 1'b0;
            non_read_d1 <= 1'b0;
            non_draw_d1 <= 1'b0;
        end
        else
        begin
            accept_d1   <= accept;
            non_read_d1 <= accept && (item.action != xsf_pkg::ACT_READ);
            non_draw_d1 <= accept && (item.action != xsf_pkg::ACT_DRAW);
        end
    end

    `XSF_ASSERT_NEXT(a_accept_busy, accept, busy)
    `XSF_ASSERT_NEXT(a_result_follows, accept_d1, done)
    `XSF_ASSERT_SAME(a_done_idle, done, !busy)
    `XSF_ASSERT_NEXT(a_row_zero, non_read_d1, result.row_pixels == '0)
    `XSF_ASSERT_NEXT(a_coll_zero, non_draw_d1, !result.collision)

endmodule

bind xor_sprite_framebuffer_core xsf_checker u_xsf_checker (.*);

`default_nettype wire

// ===== tb/xor_sprite_framebuffer_core_tb.sv =====
`timescale 1ns / 100ps

module xor_sprite_framebuffer_core_tb;

    import xsf_pkg::*;

    // action code the block leaves undecoded
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 1950;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         TAIL_CYCLES  = 10;

    // one queued item; hold_for_drain makes the driver wait until the
    // block has returned every outstanding result before sending it
    typedef struct {
        in_item_t it;
        bit       hold_for_drain;
    } pending_op_t;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  item;
    logic      done;
    out_item_t result;

    xor_sprite_framebuffer_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // model copy of the screen, one word per row, bit c is column c
    logic [ROW_BITS-1:0] frame_model [SCREEN_HEIGHT];

    pending_op_t pending_ops[$];
    out_item_t   expected_results[$];

    int issued_cnt;
    int accepted_cnt;
    int error_cnt;
    int cycle_cnt;
    int draw_cnt;
    int hit_cnt;
    int read_cnt;
    int clear_cnt;
    int odd_cnt;

    // Apply one item to the model screen and return what the block owes.
    function automatic out_item_t predict_frame_op(input in_item_t it);
        out_item_t           res;
        logic [ROW_BITS-1:0] word;
        int                  col;
        res = '0;
        case (it.action)
            ACT_DRAW:
            begin
                if (int'(it.y_pos) < SCREEN_HEIGHT)
                begin
                    word = frame_model[it.y_pos];
                    for (int k = 0; k < SPRITE_PIXELS; k++)
                    begin
                        col = int'(it.x_pos) + k;
                        // pixels at or past the right edge are dropped
                        if (col < SCREEN_WIDTH && it.sprite_bits[SPRITE_PIXELS-1-k])
                        begin
                            if (word[col])
                                res.collision = 1'b1;
                            word[col] = ~word[col];
                        end
                    end
                    frame_model[it.y_pos] = word;
                end
            end
            ACT_CLEAR:
            begin
                for (int r = 0; r < SCREEN_HEIGHT; r++)
                    frame_model[r] = '0;
            end
            ACT_READ:
            begin
                if (int'(it.y_pos) < SCREEN_HEIGHT)
                    res.row_pixels = frame_model[it.y_pos];
            end
            default:
            begin
                // unused action: no state change, all-zero result
            end
        endcase
        return res;
    endfunction

    function automatic in_item_t make_op(input logic [1:0] act, input logic [5:0] x,
                                         input logic [4:0] y, input logic [7:0] bits);
        in_item_t it;
        it.action      = action_t'(act);
        it.x_pos       = x;
        it.y_pos       = y;
        it.sprite_bits = bits;
        return it;
    endfunction

    task automatic queue_op(input in_item_t it, input bit drain);
        pending_op_t p;
        p.it             = it;
        p.hold_for_drain = drain;
        pending_ops.push_back(p);
    endtask

    // Random item mix: mostly draws so rows fill and collide, a steady
    // share of reads for scan-out, rare clears and the odd unused code.
    function automatic in_item_t random_op();
        int          pick;
        logic [1:0]  act;
        logic [5:0]  x;
        logic [4:0]  y;
        pick = $urandom_range(99, 0);
        if (pick < 66)
            act = ACT_DRAW;
        else if (pick < 94)
            act = ACT_READ;
        else if (pick < 97)
            act = ACT_CLEAR;
        else
            act = ACT_UNUSED;
        x = 6'($urandom_range(63, 0));
        // lean on the right edge now and then
        if ($urandom_range(9, 0) == 0)
            x = 6'($urandom_range(63, 56));
        // cluster on a few rows so draws overlap more often
        y = ($urandom_range(3, 0) == 0) ? 5'($urandom_range(3, 0))
                                        : 5'($urandom_range(31, 0));
        return make_op(act, x, y, 8'($urandom_range(255, 0)));
    endfunction

    // Driver: inputs move on the falling edge. An item stays up until the
    // monitor has seen it taken; start changes at most once per edge.
    always @(negedge clk)
    begin
        bit       go;
        bit       idle_now;
        in_item_t nxt;
        if (rst_n)
        begin
            if (!(start && accepted_cnt != issued_cnt))
            begin
                go  = 1'b0;
                nxt = item;
                // no idling while the long burst window is open
                idle_now = (issued_cnt < 700 || issued_cnt >= 1000) &&
                           ($urandom_range(99, 0) < 35);
                if (pending_ops.size() != 0 && !idle_now)
                begin
                    if (!(pending_ops[0].hold_for_drain && expected_results.size() != 0))
                    begin
                        go  = 1'b1;
                        nxt = pending_ops[0].it;
                        void'(pending_ops.pop_front());
                        issued_cnt++;
                    end
                end
                start <= go;
                item  <= nxt;
            end
        end
    end

    // Monitor: results and acceptances sampled on the rising edge. The
    // result check runs first so a strobe and a new accept in one cycle
    // keep the expectation queue in order.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result collision=%0b row_pixels=%016h",
                             $time, result.collision, result.row_pixels);
                    error_cnt++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.collision !== want.collision)
                    begin
                        $display("%0t: collision mismatch expected %0b actual %0b",
                                 $time, want.collision, result.collision);
                        error_cnt++;
                    end
                    if (result.row_pixels !== want.row_pixels)
                    begin
                        $display("%0t: row_pixels mismatch expected %016h actual %016h",
                                 $time, want.row_pixels, result.row_pixels);
                        error_cnt++;
                    end
                    if (want.collision)
                        hit_cnt++;
                end
            end
            if (start && !busy)
            begin
                accepted_cnt++;
                case (item.action)
                    ACT_DRAW:  draw_cnt++;
                    ACT_READ:  read_cnt++;
                    ACT_CLEAR: clear_cnt++;
                    default:   odd_cnt++;
                endcase
                expected_results.push_back(predict_frame_op(item));
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;
        issued_cnt   = 0;
        accepted_cnt = 0;
        error_cnt    = 0;
        cycle_cnt    = 0;
        draw_cnt     = 0;
        hit_cnt      = 0;
        read_cnt     = 0;
        clear_cnt    = 0;
        odd_cnt      = 0;
        for (int r = 0; r < SCREEN_HEIGHT; r++)
            frame_model[r] = '0;

        // directed part: edges, every action, collision, dropped pixels
        queue_op(make_op(ACT_READ,   6'd0,  5'd0,  8'h00), 1'b0); // fresh screen reads 0
        queue_op(make_op(ACT_DRAW,   6'd0,  5'd0,  8'hFF), 1'b0);
        queue_op(make_op(ACT_READ,   6'd0,  5'd0,  8'h00), 1'b0);
        queue_op(make_op(ACT_DRAW,   6'd0,  5'd0,  8'hFF), 1'b0); // erase: collision
        queue_op(make_op(ACT_READ,   6'd63, 5'd0,  8'hFF), 1'b0);
        queue_op(make_op(ACT_DRAW,   6'd56, 5'd31, 8'hFF), 1'b0); // fits up to column 63
        queue_op(make_op(ACT_DRAW,   6'd57, 5'd30, 8'hFF), 1'b0); // last pixel dropped
        queue_op(make_op(ACT_DRAW,   6'd63, 5'd29, 8'hFF), 1'b0); // only one pixel lands
        queue_op(make_op(ACT_DRAW,   6'd63, 5'd28, 8'h7F), 1'b0); // nothing lands
        queue_op(make_op(ACT_READ,   6'd0,  5'd31, 8'h00), 1'b0);
        queue_op(make_op(ACT_READ,   6'd0,  5'd30, 8'h00), 1'b0);
        queue_op(make_op(ACT_READ,   6'd0,  5'd29, 8'h00), 1'b0);
        queue_op(make_op(ACT_READ,   6'd0,  5'd28, 8'h00), 1'b0);
        queue_op(make_op(ACT_DRAW,   6'd60, 5'd31, 8'hA5), 1'b0); // partial overlap
        queue_op(make_op(ACT_DRAW,   6'd5,  5'd15, 8'h00), 1'b0); // empty sprite
        queue_op(make_op(ACT_DRAW,   6'd5,  5'd15, 8'h81), 1'b0);
        queue_op(make_op(ACT_DRAW,   6'd12, 5'd15, 8'h01), 1'b0); // hits column 19 only
        queue_op(make_op(ACT_UNUSED, 6'd63, 5'd31, 8'hFF), 1'b0); // undecoded action
        queue_op(make_op(ACT_READ,   6'd0,  5'd15, 8'h00), 1'b0);
        queue_op(make_op(ACT_CLEAR,  6'd63, 5'd31, 8'hFF), 1'b0);
        queue_op(make_op(ACT_READ,   6'd0,  5'd31, 8'h00), 1'b0);
        queue_op(make_op(ACT_READ,   6'd0,  5'd15, 8'h00), 1'b0);
        queue_op(make_op(ACT_DRAW,   6'd63, 5'd31, 8'h80), 1'b0); // corner pixel
        queue_op(make_op(ACT_READ,   6'd0,  5'd31, 8'h00), 1'b0);

        // random part, with two points where the sender waits for a full drain
        for (int n = 0; n < RANDOM_ITEMS; n++)
            queue_op(random_op(), (n == 500 || n == 1400));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for the last item to be taken and every result to come back
        while (pending_ops.size() != 0 || accepted_cnt != issued_cnt ||
               expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            error_cnt++;
        end

        $display("covered %0d draws (%0d with collision), %0d reads, %0d clears, %0d unused",
                 draw_cnt, hit_cnt, read_cnt, clear_cnt, odd_cnt);
        $display("items taken %0d, mismatches %0d", accepted_cnt, error_cnt);
        if (error_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
